### src/swp_pkg.sv
// ----------------------------------------------------------------------------
// swp_pkg: shared types and constants of the swipe gesture classifier
// Payload structs, configuration layout, direction codes and back-end states.
// ----------------------------------------------------------------------------
package swp_pkg;

	// default geometry
	localparam int COORD_BITS_DEF  = 16;
	localparam int TIME_BITS_DEF   = 32;
	localparam int QUEUE_DEPTH_DEF = 2;

	// datapath widths
	localparam int MAG_W      = 17;          // |delta| of two 16-bit coordinates
	localparam int PROD_W     = MAG_W + 8;   // magnitude times ratio register
	localparam int NUM_W      = MAG_W + 10;  // magnitude times 1000
	localparam int DUR_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// scaling constants
	localparam logic [9:0] SPEED_SCALE = 10'd1000;
	localparam logic [3:0] RATIO_SCALE = 4'd10;

	// register reset values
	localparam logic [15:0] RST_MIN_TRAVEL   = 16'd36;
	localparam logic [15:0] RST_SURE_TRAVEL  = 16'd80;
	localparam logic [15:0] RST_MIN_SPEED    = 16'd120;
	localparam logic [7:0]  RST_DOMINANCE    = 8'd14;
	localparam logic [31:0] RST_MAX_DURATION = 32'd1500;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_TRAVEL   = 3'd0,
		CFG_SURE_TRAVEL  = 3'd1,
		CFG_MIN_SPEED    = 3'd2,
		CFG_DOMINANCE    = 3'd3,
		CFG_MAX_DURATION = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		DIR_RIGHT = 2'd0,
		DIR_LEFT  = 2'd1,
		DIR_DOWN  = 2'd2,
		DIR_UP    = 2'd3
	} dir_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CHECK,
		BK_DIV,
		BK_EMIT
	} back_state_t;

	typedef struct packed {
		logic               pressed;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [31:0]        now_ms;
	} in_item_t;

	typedef struct packed {
		dir_t               direction;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
		logic signed [15:0] delta_x;
		logic signed [15:0] delta_y;
		logic [31:0]        duration;
	} out_item_t;

	// finished stroke handed from front to back
	typedef struct packed {
		logic signed [15:0]      start_x;
		logic signed [15:0]      start_y;
		logic signed [MAG_W-1:0] dx;
		logic signed [MAG_W-1:0] dy;
		logic [DUR_W-1:0]        dur;
	} stroke_t;

	typedef struct packed {
		logic [15:0] min_travel;
		logic [15:0] sure_travel;
		logic [15:0] min_speed_milli;
		logic [7:0]  dominance_tenths;
		logic [31:0] max_duration;
	} cfg_t;

endpackage

### src/swp_front.sv
// ----------------------------------------------------------------------------
// swp_front: touch sample tracker
// Follows press and release, latches start point and time, and queues a
// finished stroke on release.
// ----------------------------------------------------------------------------
module swp_front #(
	parameter int COORD_BITS = swp_pkg::COORD_BITS_DEF,
	parameter int TIME_BITS  = swp_pkg::TIME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  swp_pkg::in_item_t in_data,
	output logic              push,
	output swp_pkg::stroke_t  push_data,
	input  logic              full
);

	logic                         accept;
	logic signed [COORD_BITS-1:0] cx;
	logic signed [COORD_BITS-1:0] cy;
	logic [TIME_BITS-1:0]         now_t;
	logic [TIME_BITS-1:0]         dur_t;
	logic                         touch_down_q;
	logic signed [COORD_BITS-1:0] origin_x_q;
	logic signed [COORD_BITS-1:0] origin_y_q;
	logic signed [COORD_BITS-1:0] last_x_q;
	logic signed [COORD_BITS-1:0] last_y_q;
	logic [TIME_BITS-1:0]         origin_time_q;

	// request handshake; a full queue holds off every sample
	assign in_stall = full;
	assign accept   = in_valid && !full;

	// coordinates keep their low bits, time wraps at the timer width
	assign cx    = in_data.pos_x[COORD_BITS-1:0];
	assign cy    = in_data.pos_y[COORD_BITS-1:0];
	assign now_t = in_data.now_ms[TIME_BITS-1:0];
	assign dur_t = now_t - origin_time_q;

	// release of an active press closes the stroke
	assign push = accept && !in_data.pressed && touch_down_q;

	always_comb begin
		push_data.start_x = 16'(origin_x_q);
		push_data.start_y = 16'(origin_y_q);
		push_data.dx      = swp_pkg::MAG_W'(last_x_q) - swp_pkg::MAG_W'(origin_x_q);
		push_data.dy      = swp_pkg::MAG_W'(last_y_q) - swp_pkg::MAG_W'(origin_y_q);
		push_data.dur     = swp_pkg::DUR_W'(dur_t);
	end

	// stroke state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_down_q  <= 1'b0;
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			origin_time_q <= '0;
			last_x_q      <= '0;
			last_y_q      <= '0;
		end else if (accept) begin
			if (in_data.pressed) begin
				if (!touch_down_q) begin
					touch_down_q  <= 1'b1;
					origin_x_q    <= cx;
					origin_y_q    <= cy;
					origin_time_q <= now_t;
				end
				last_x_q <= cx;
				last_y_q <= cy;
			end else begin
				touch_down_q <= 1'b0;
			end
		end
	end

endmodule

### src/swp_fifo.sv
// ----------------------------------------------------------------------------
// swp_fifo: stroke queue
// Short first-in first-out buffer between the sample tracker and the
// classifier.
// ----------------------------------------------------------------------------
module swp_fifo #(
	parameter int DEPTH = swp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  swp_pkg::stroke_t push_data,
	output logic             full,
	input  logic             pop,
	output swp_pkg::stroke_t pop_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	swp_pkg::stroke_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### src/swp_back.sv
// ----------------------------------------------------------------------------
// swp_back: stroke classifier
// Checks duration, travel and axis dominance, divides for the speed test
// one quotient bit per cycle, and holds the swipe in an output register.
// ----------------------------------------------------------------------------
module swp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  swp_pkg::cfg_t      cfg,
	input  logic               empty,
	output logic               pop,
	input  swp_pkg::stroke_t   pop_data,
	output logic               out_valid,
	input  logic               out_stall,
	output swp_pkg::out_item_t out_data
);

	localparam int MAG_W  = swp_pkg::MAG_W;
	localparam int PROD_W = swp_pkg::PROD_W;
	localparam int NUM_W  = swp_pkg::NUM_W;
	localparam int DUR_W  = swp_pkg::DUR_W;
	localparam int CNT_W  = $clog2(NUM_W);

	swp_pkg::back_state_t state_q;
	swp_pkg::back_state_t state_d;
	swp_pkg::stroke_t     rec_q;
	logic [MAG_W-1:0]     major_q;
	logic [MAG_W-1:0]     minor_q;
	logic                 horiz_q;
	logic                 need_div_q;
	logic [DUR_W-1:0]     rem_q;
	logic [NUM_W-1:0]     quo_q;
	logic [DUR_W-1:0]     div_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 out_valid_q;
	swp_pkg::out_item_t   out_q;

	logic [MAG_W-1:0] ax;
	logic [MAG_W-1:0] ay;
	logic             hz;
	logic             reject;
	logic             need_div;
	logic [DUR_W:0]   trial;
	logic [DUR_W:0]   diff;
	logic             take;
	logic             last_step;
	logic             slow;
	logic             slot_free;
	logic             load_out;
	swp_pkg::dir_t    dir;

	// magnitudes of the queue head
	always_comb begin
		ax = pop_data.dx[MAG_W-1] ? MAG_W'(-pop_data.dx) : MAG_W'(pop_data.dx);
		ay = pop_data.dy[MAG_W-1] ? MAG_W'(-pop_data.dy) : MAG_W'(pop_data.dy);
		hz = ax > ay;
	end

	// acceptance tests on the loaded stroke
	always_comb begin
		reject = (rec_q.dur > cfg.max_duration) ||
			(major_q < MAG_W'(cfg.min_travel)) ||
			(PROD_W'(major_q) * PROD_W'(swp_pkg::RATIO_SCALE) <
			 PROD_W'(minor_q) * PROD_W'(cfg.dominance_tenths));
		need_div = major_q < MAG_W'(cfg.sure_travel);
	end

	// restoring divide step
	always_comb begin
		trial     = {rem_q, quo_q[NUM_W-1]};
		diff      = trial - {1'b0, div_q};
		take      = trial >= {1'b0, div_q};
		last_step = (cnt_q == CNT_W'(NUM_W - 1));
	end

	// speed test, output slot and direction
	always_comb begin
		slow      = need_div_q && (quo_q < NUM_W'(cfg.min_speed_milli));
		slot_free = !out_valid_q || !out_stall;
		if (horiz_q) begin
			dir = (!rec_q.dx[MAG_W-1] && rec_q.dx != '0) ?
				swp_pkg::DIR_RIGHT : swp_pkg::DIR_LEFT;
		end else begin
			dir = (!rec_q.dy[MAG_W-1] && rec_q.dy != '0) ?
				swp_pkg::DIR_DOWN : swp_pkg::DIR_UP;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			swp_pkg::BK_IDLE: begin
				if (!empty) state_d = swp_pkg::BK_CHECK;
			end
			swp_pkg::BK_CHECK: begin
				if (reject) state_d = swp_pkg::BK_IDLE;
				else if (need_div) state_d = swp_pkg::BK_DIV;
				else state_d = swp_pkg::BK_EMIT;
			end
			swp_pkg::BK_DIV: begin
				if (last_step) state_d = swp_pkg::BK_EMIT;
			end
			swp_pkg::BK_EMIT: begin
				if (slow || slot_free) state_d = swp_pkg::BK_IDLE;
			end
			default: state_d = swp_pkg::BK_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			swp_pkg::BK_IDLE:  pop = !empty;
			swp_pkg::BK_CHECK: ;
			swp_pkg::BK_DIV:   ;
			swp_pkg::BK_EMIT:  load_out = !slow && slot_free;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swp_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == swp_pkg::BK_CHECK) begin
				cnt_q <= '0;
			end else if (state_q == swp_pkg::BK_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q   <= pop_data;
			major_q <= hz ? ax : ay;
			minor_q <= hz ? ay : ax;
			horiz_q <= hz;
		end
		if (state_q == swp_pkg::BK_CHECK) begin
			need_div_q <= need_div;
			rem_q      <= '0;
			quo_q      <= NUM_W'(major_q) * NUM_W'(swp_pkg::SPEED_SCALE);
			div_q      <= (rec_q.dur == '0) ? DUR_W'(1) : rec_q.dur;
		end
		if (state_q == swp_pkg::BK_DIV) begin
			rem_q <= take ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], take};
		end
		if (load_out) begin
			out_q.direction <= dir;
			out_q.start_x   <= rec_q.start_x;
			out_q.start_y   <= rec_q.start_y;
			out_q.delta_x   <= rec_q.dx[15:0];
			out_q.delta_y   <= rec_q.dy[15:0];
			out_q.duration  <= rec_q.dur;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// divider keeps a partial remainder below a nonzero divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == swp_pkg::BK_DIV |-> rem_q < div_q)
		else $error("swp_back: remainder not below divisor");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == swp_pkg::BK_DIV |-> div_q != '0)
		else $error("swp_back: zero divisor");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == swp_pkg::BK_DIV && last_step) |=> state_q == swp_pkg::BK_EMIT)
		else $error("swp_back: divide did not finish on count");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != swp_pkg::BK_IDLE |-> major_q >= minor_q)
		else $error("swp_back: major axis smaller than minor");

endmodule

### src/swipe_gesture_classifier.sv
// ----------------------------------------------------------------------------
// swipe_gesture_classifier: touch swipe detector, top level
// Path: a release sample is queued, then popped and checked, and the swipe
//   is registered; a short stroke runs the speed divide (27 quotient bits) too.
// Throughput: one sample per cycle while the stroke queue has room; the
//   classifier takes a new stroke only when it is done with the last one.
// Reset: registers return to their defaults, no press is active, queue empty.
// ----------------------------------------------------------------------------
module swipe_gesture_classifier #(
	parameter int COORD_BITS  = swp_pkg::COORD_BITS_DEF,
	parameter int TIME_BITS   = swp_pkg::TIME_BITS_DEF,
	parameter int QUEUE_DEPTH = swp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [swp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [swp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  swp_pkg::in_item_t                in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output swp_pkg::out_item_t               out_data
);

	swp_pkg::cfg_t    cfg_q;
	logic             push;
	logic             full;
	logic             pop;
	logic             empty;
	swp_pkg::stroke_t push_data;
	swp_pkg::stroke_t pop_data;

	// configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_travel       <= swp_pkg::RST_MIN_TRAVEL;
			cfg_q.sure_travel      <= swp_pkg::RST_SURE_TRAVEL;
			cfg_q.min_speed_milli  <= swp_pkg::RST_MIN_SPEED;
			cfg_q.dominance_tenths <= swp_pkg::RST_DOMINANCE;
			cfg_q.max_duration     <= swp_pkg::RST_MAX_DURATION;
		end else if (cfg_we) begin
			unique case (cfg_index)
				swp_pkg::CFG_MIN_TRAVEL:   cfg_q.min_travel       <= cfg_data[15:0];
				swp_pkg::CFG_SURE_TRAVEL:  cfg_q.sure_travel      <= cfg_data[15:0];
				swp_pkg::CFG_MIN_SPEED:    cfg_q.min_speed_milli  <= cfg_data[15:0];
				swp_pkg::CFG_DOMINANCE:    cfg_q.dominance_tenths <= cfg_data[7:0];
				swp_pkg::CFG_MAX_DURATION: cfg_q.max_duration     <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// sample tracking
	swp_front #(
		.COORD_BITS (COORD_BITS),
		.TIME_BITS  (TIME_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	// stroke queue
	swp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	// classification and result register
	swp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.empty     (empty),
		.pop       (pop),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

### dv/tb_swipe_gesture_classifier.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_swipe_gesture_classifier: self-checking bench for the swipe classifier
// Feeds touch strokes and loose samples through the valid/stall handshake,
// works out every swipe with an in-bench classifier and compares each swipe
// that leaves the block, field by field and in order.
// ----------------------------------------------------------------------------
module tb_swipe_gesture_classifier;
	import swp_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 5;
	localparam int SETTLE_CYCLES  = 40;        // time for the back end to settle
	localparam int TIMEOUT_CYCLES = 1_000_000;
	localparam int MAX_SHOWN      = 10;
	localparam logic [CFG_IDX_W-1:0] SPARE_IDX_FIRST = CFG_IDX_W'(CFG_MAX_DURATION + 1);

	typedef enum {RX_FREE, RX_CHOPPY, RX_BURSTY} rx_pattern_e;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_data;

	// classifier copy kept by the bench
	cfg_t               model_cfg;
	logic               pen_down;
	logic signed [15:0] org_x;
	logic signed [15:0] org_y;
	logic [31:0]        org_t;
	logic signed [15:0] cur_x;
	logic signed [15:0] cur_y;
	out_item_t          swipes_due[$];

	int          bad_count;
	int          samples_sent;
	logic [31:0] ms_clock;

	// sender and receiver idling controls
	bit          tx_gaps;
	int          burst_left;
	rx_pattern_e rx_pattern;
	int          rx_hold_req;
	int          hold_left;
	int          run_left;
	bit          run_on;

	swipe_gesture_classifier i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// hard stop if the run hangs
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic void note_error(string msg);
		bad_count++;
		if (bad_count <= MAX_SHOWN) begin
			$display("%0t: %s", $time, msg);
		end
	endfunction

	function automatic in_item_t touch_sample(logic p, logic [15:0] x, logic [15:0] y,
			logic [31:0] t);
		in_item_t s;
		s.pressed = p;
		s.pos_x   = x;
		s.pos_y   = y;
		s.now_ms  = t;
		return s;
	endfunction

	// follow one accepted sample; on release decide whether a swipe is due
	function automatic void classify_sample(in_item_t s);
		int                dx, dy, ax, ay, major, minor;
		bit                horiz;
		logic [31:0]       dur;
		longint unsigned   num, den, rate;
		out_item_t         res;
		if (s.pressed) begin
			if (!pen_down) begin
				pen_down = 1'b1;
				org_x    = s.pos_x;
				org_y    = s.pos_y;
				org_t    = s.now_ms;
			end
			cur_x = s.pos_x;
			cur_y = s.pos_y;
			return;
		end
		// release with no press in progress is dropped
		if (!pen_down) return;
		pen_down = 1'b0;

		dur   = s.now_ms - org_t;
		dx    = int'(cur_x) - int'(org_x);
		dy    = int'(cur_y) - int'(org_y);
		ax    = (dx < 0) ? -dx : dx;
		ay    = (dy < 0) ? -dy : dy;
		horiz = ax > ay;
		major = horiz ? ax : ay;
		minor = horiz ? ay : ax;

		if (dur > model_cfg.max_duration || major < int'(model_cfg.min_travel)) return;
		if (longint'(major) * RATIO_SCALE < longint'(minor) * model_cfg.dominance_tenths)
			return;
		// zero duration divides as one millisecond
		num  = major;
		num  = num * SPEED_SCALE;
		den  = (dur == 0) ? 64'd1 : 64'(dur);
		rate = num / den;
		if (major < int'(model_cfg.sure_travel) && rate < model_cfg.min_speed_milli) return;

		// a tie between the axes goes vertical
		if (horiz) res.direction = (dx > 0) ? DIR_RIGHT : DIR_LEFT;
		else       res.direction = (dy > 0) ? DIR_DOWN : DIR_UP;
		res.start_x  = org_x;
		res.start_y  = org_y;
		res.delta_x  = dx[15:0];
		res.delta_y  = dy[15:0];
		res.duration = dur;
		swipes_due.push_back(res);
	endfunction

	function automatic void check_swipe(out_item_t got);
		out_item_t want;
		if (swipes_due.size() == 0) begin
			note_error($sformatf("swipe with none due: dir=%0d sx=%0d sy=%0d dx=%0d dy=%0d dur=%0d",
				got.direction, got.start_x, got.start_y, got.delta_x, got.delta_y,
				got.duration));
			return;
		end
		want = swipes_due.pop_front();
		if (got.direction !== want.direction || got.start_x !== want.start_x ||
				got.start_y !== want.start_y || got.delta_x !== want.delta_x ||
				got.delta_y !== want.delta_y || got.duration !== want.duration) begin
			note_error($sformatf({"swipe mismatch: expected dir=%0d sx=%0d sy=%0d dx=%0d ",
				"dy=%0d dur=%0d, got dir=%0d sx=%0d sy=%0d dx=%0d dy=%0d dur=%0d"},
				want.direction, want.start_x, want.start_y, want.delta_x, want.delta_y,
				want.duration, got.direction, got.start_x, got.start_y, got.delta_x,
				got.delta_y, got.duration));
		end
	endfunction

	// results first, then the request taken at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) check_swipe(out_data);
			if (in_valid && !in_stall) classify_sample(in_data);
		end
	end

	// receiver stall pattern, with an optional long hold-off
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		run_left  = 0;
		run_on    = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req != 0) begin
				hold_left   = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (rx_pattern)
					RX_FREE: out_stall <= 1'b0;
					RX_CHOPPY: out_stall <= ($urandom_range(0, 2) == 0);
					default: begin
						if (run_left == 0) begin
							run_left = $urandom_range(1, 10);
							run_on   = !run_on;
						end
						run_left--;
						out_stall <= run_on;
					end
				endcase
			end
		end
	end

	// one request, held until the block takes it
	task automatic push_sample(in_item_t s);
		int gap;
		if (tx_gaps) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
				repeat (gap) begin
					@(negedge clk);
					in_valid <= 1'b0;
				end
			end
			burst_left--;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= s;
		do @(posedge clk); while (in_stall);
		samples_sent++;
	endtask

	// stop sending, let every due swipe out, then let the back end settle
	task automatic wait_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		while (swipes_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			CFG_MIN_TRAVEL:   model_cfg.min_travel       = val[15:0];
			CFG_SURE_TRAVEL:  model_cfg.sure_travel      = val[15:0];
			CFG_MIN_SPEED:    model_cfg.min_speed_milli  = val[15:0];
			CFG_DOMINANCE:    model_cfg.dominance_tenths = val[7:0];
			CFG_MAX_DURATION: model_cfg.max_duration     = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// full register set, upper data bits carry junk the block must drop
	task automatic load_config(logic [15:0] travel, logic [15:0] sure, logic [15:0] speed,
			logic [7:0] dom, logic [31:0] dur_max);
		wait_quiet();
		write_reg(CFG_MIN_TRAVEL, {16'($urandom), travel});
		write_reg(CFG_SURE_TRAVEL, {16'($urandom), sure});
		write_reg(CFG_MIN_SPEED, {16'($urandom), speed});
		write_reg(CFG_DOMINANCE, {24'($urandom), dom});
		write_reg(CFG_MAX_DURATION, dur_max);
	endtask

	task automatic load_random_config();
		load_config(16'($urandom_range(0, 200)), 16'($urandom_range(0, 400)),
			16'($urandom_range(0, 2000)), 8'($urandom_range(0, 40)), $urandom_range(0, 3000));
	endtask

	// press, optional moves ending on the target point, release
	task automatic run_stroke(logic signed [15:0] x0, logic signed [15:0] y0, int dx, int dy,
			logic [31:0] t0, logic [31:0] dur, int nmoves);
		logic signed [15:0] xe, ye;
		int i;
		xe = 16'(int'(x0) + dx);
		ye = 16'(int'(y0) + dy);
		push_sample(touch_sample(1'b1, x0, y0, t0));
		for (i = 1; i < nmoves; i++) begin
			push_sample(touch_sample(1'b1, 16'($urandom), 16'($urandom), $urandom));
		end
		if (nmoves > 0) push_sample(touch_sample(1'b1, xe, ye, $urandom));
		push_sample(touch_sample(1'b0, 16'($urandom), 16'($urandom), t0 + dur));
	endtask

	function automatic int clamp_mag(int v);
		if (v < 0) return 0;
		if (v > 65535) return 65535;
		return v;
	endfunction

	// stroke sized around the current thresholds
	task automatic random_stroke();
		int                 major, minor, dx, dy;
		logic [31:0]        dur, t0;
		logic signed [15:0] x0, y0;
		case ($urandom_range(0, 5))
			0: major = int'(model_cfg.min_travel) + $urandom_range(0, 4) - 2;
			1: major = int'(model_cfg.sure_travel) + $urandom_range(0, 4) - 2;
			2: major = $urandom_range(0, 300);
			3: major = $urandom_range(0, 65535);
			default: major = $urandom_range(40, 2000);
		endcase
		major = clamp_mag(major);
		case ($urandom_range(0, 3))
			0: begin
				if (model_cfg.dominance_tenths == 0) minor = major;
				else minor = (major * 10) / model_cfg.dominance_tenths + $urandom_range(0, 2) - 1;
			end
			1: minor = 0;
			2: minor = $urandom_range(0, major);
			default: minor = major;
		endcase
		minor = clamp_mag(minor);
		case ($urandom_range(0, 4))
			0: dur = model_cfg.max_duration + $urandom_range(0, 2) - 1;
			1: begin
				if (model_cfg.min_speed_milli == 0) dur = $urandom_range(0, 3000);
				else dur = (major * 1000) / model_cfg.min_speed_milli + $urandom_range(0, 2) - 1;
			end
			2: dur = $urandom_range(0, 2);
			3: dur = $urandom_range(0, 3000);
			default: dur = $urandom;
		endcase
		if ($urandom_range(0, 1)) begin
			dx = major;
			dy = minor;
		end else begin
			dx = minor;
			dy = major;
		end
		if ($urandom_range(0, 1)) dx = -dx;
		if ($urandom_range(0, 1)) dy = -dy;
		x0 = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000) - 1000);
		y0 = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000) - 1000);
		if ($urandom_range(0, 15) == 0) ms_clock = $urandom;
		t0 = ms_clock;
		run_stroke(x0, y0, dx, dy, t0, dur, $urandom_range(0, 3));
		ms_clock = t0 + dur + $urandom_range(1, 500);
	endtask

	// mostly whole strokes, some loose samples that break them up
	task automatic random_phase(int count);
		int first;
		first = samples_sent;
		while (samples_sent - first < count) begin
			if ($urandom_range(0, 9) == 0)
				push_sample(touch_sample(1'($urandom_range(0, 1)), 16'($urandom),
					16'($urandom), $urandom));
			else
				random_stroke();
		end
	endtask

	// hand-picked strokes under the reset thresholds
	task automatic test_default_strokes();
		tx_gaps    = 1'b1;
		rx_pattern = RX_CHOPPY;
		// release with no press
		push_sample(touch_sample(1'b0, 16'sd123, -16'sd45, 32'd1000));
		// plain fast right swipe
		run_stroke(0, 0, 100, 5, 32'd2000, 32'd200, 1);
		// zero duration, short travel, left
		run_stroke(300, -200, -40, 2, 32'd3000, 32'd0, 1);
		// timestamp wraps between press and release, down
		run_stroke(-7, 64, 3, 90, 32'hFFFF_FFFF, 32'd100, 2);
		// exactly at the duration limit, up
		run_stroke(0, 0, 0, -120, 32'h0000_1000, 32'd1500, 1);
		// short and slow
		run_stroke(10, 10, 50, 0, 32'd9000, 32'd1000, 1);
		// one millisecond too long
		run_stroke(10, 10, 200, 0, 32'd12000, 32'd1501, 1);
	endtask

	// registers at both ends of their range
	task automatic test_register_extremes();
		load_config('0, '0, '0, '0, '0);
		write_reg(CFG_IDX_W'($urandom_range(SPARE_IDX_FIRST, (1 << CFG_IDX_W) - 1)), $urandom);
		// no travel at all: tie with dy zero goes up
		run_stroke(5, 5, 0, 0, 32'd20000, 32'd0, 0);
		// diagonal tie going down
		run_stroke(-9, 20, 7, 7, 32'd21000, 32'd0, 1);
		load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
		// full-span strokes, deltas wrap on output
		run_stroke(-32768, 0, 65535, 0, 32'd0, 32'hFFFF_FFFF, 1);
		run_stroke(0, 32767, 0, -65535, 32'd500, 32'd0, 1);
	endtask

	// long receiver hold while strokes keep coming, then a full drain
	task automatic test_backpressure();
		load_config(RST_MIN_TRAVEL, RST_SURE_TRAVEL, RST_MIN_SPEED, RST_DOMINANCE,
			RST_MAX_DURATION);
		tx_gaps     = 1'b0;
		rx_pattern  = RX_FREE;
		rx_hold_req = 400;
		repeat (20) begin
			run_stroke(16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
				$urandom_range(200, 600), $urandom_range(0, 10), ms_clock, 32'd100, 1);
			ms_clock = ms_clock + 300;
		end
		wait_quiet();
		tx_gaps    = 1'b1;
		rx_pattern = RX_BURSTY;
		random_phase(60);
	endtask

	// random strokes under a series of register settings
	task automatic test_random_strokes();
		tx_gaps    = 1'b1;
		rx_pattern = RX_CHOPPY;
		load_config(RST_MIN_TRAVEL, RST_SURE_TRAVEL, RST_MIN_SPEED, RST_DOMINANCE,
			RST_MAX_DURATION);
		random_phase(300);

		// no idling on either side
		tx_gaps    = 1'b0;
		rx_pattern = RX_FREE;
		load_random_config();
		random_phase(250);

		tx_gaps    = 1'b1;
		rx_pattern = RX_BURSTY;
		load_random_config();
		random_phase(250);

		rx_pattern = RX_CHOPPY;
		load_config('0, '0, '0, '0, '0);
		random_phase(200);

		rx_pattern = RX_BURSTY;
		load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
		random_phase(150);

		rx_pattern = RX_CHOPPY;
		load_config(16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), $urandom);
		random_phase(150);

		rx_pattern = RX_BURSTY;
		load_random_config();
		random_phase(300);
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		in_data     = '0;
		bad_count   = 0;
		samples_sent = 0;
		burst_left  = 0;
		tx_gaps     = 1'b0;
		rx_pattern  = RX_FREE;
		rx_hold_req = 0;
		ms_clock    = $urandom;
		pen_down    = 1'b0;
		org_x       = '0;
		org_y       = '0;
		org_t       = '0;
		cur_x       = '0;
		cur_y       = '0;
		model_cfg.min_travel       = RST_MIN_TRAVEL;
		model_cfg.sure_travel      = RST_SURE_TRAVEL;
		model_cfg.min_speed_milli  = RST_MIN_SPEED;
		model_cfg.dominance_tenths = RST_DOMINANCE;
		model_cfg.max_duration     = RST_MAX_DURATION;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_strokes();
		test_register_extremes();
		test_backpressure();
		test_random_strokes();
		wait_quiet();

		if (bad_count == 0 && swipes_due.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
